// ----- sv/mpbd_pkg.sv -----
`timescale 1ns / 1ps
package mpbd_pkg;

  localparam int unsigned MAX_WIDTH_DEF   = 1024;
  localparam int unsigned MAX_HEIGHT_DEF  = 1024;
  localparam int unsigned LEVEL_COUNT_DEF = 10;

  localparam int unsigned FRAC_BITS  = 18;
  localparam int unsigned CHAN_W     = 26;
  localparam int unsigned PAIR_W     = 27;
  localparam int unsigned QUAD_W     = 28;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned LEVEL_W    = 4;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 104;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

endpackage

// ----- sv/mpbd_ram.sv -----
`timescale 1ns / 1ps
module mpbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/mip_pyramid_box_downsampler_unit.sv -----
`timescale 1ns / 1ps
// Builds a full 2x2 box mip pyramid from level-0 RGB pixels streamed in raster
// order. Each input word yields its level-0 pixel and, whenever it completes a
// 2x2 block, the averaged pixel of each next level, lowest level first; tlast
// marks the final output word of an input word. Channels carry 18 fraction bits.
// For each input word a single sequencer walks the levels and reads the shared
// pair-sum line RAM once per level; output stalls hold the sequencer. Writing a
// size register restarts the frame.
module mip_pyramid_box_downsampler_unit #(
  parameter int unsigned MAX_WIDTH   = mpbd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT  = mpbd_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned LEVEL_COUNT = mpbd_pkg::LEVEL_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [mpbd_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // Fields from bit 0: red_in, green_in, blue_in.
  input  logic [mpbd_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // Fields from bit 0: level, column, row, red_out, green_out, blue_out, zero fill.
  output logic [mpbd_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tlast
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned LW = $clog2(LEVEL_COUNT + 1);
  localparam int unsigned CH = mpbd_pkg::CHAN_W;
  localparam int unsigned PW = mpbd_pkg::PAIR_W;
  localparam int unsigned QW = mpbd_pkg::QUAD_W;

  mpbd_pkg::state_t state, state_next;

  logic [mpbd_pkg::CFG_W-1:0] image_width, image_height;
  logic [31:0] w_eff, h_eff;
  logic [CW-1:0] col_q [LEVEL_COUNT];
  logic [RW-1:0] row_q [LEVEL_COUNT];
  logic [CH-1:0] held [LEVEL_COUNT][3];
  logic [CH-1:0] vals [3];
  logic [LW-1:0] lvl;

  logic [CW-1:0] cur_c;
  logic [RW-1:0] cur_r;
  logic [LW-1:0] child;
  logic          child_ok, pair_done, produced, out_fire, in_fire;
  logic [31:0]   lvl_w, lvl_h, slot32;
  logic [CW-1:0] slot;
  logic [3*PW-1:0] ram_wdata, ram_rdata;
  logic          ram_we;
  logic [PW-1:0] pair [3];
  logic [QW-1:0] quad [3];

  always_comb begin
    w_eff = 32'(image_width);
    if (image_width == '0) begin
      w_eff = 32'd1;
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = MAX_WIDTH;
    end
    h_eff = 32'(image_height);
    if (image_height == '0) begin
      h_eff = 32'd1;
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end
  end

  assign cur_c    = col_q[lvl[$clog2(LEVEL_COUNT)-1:0]];
  assign cur_r    = row_q[lvl[$clog2(LEVEL_COUNT)-1:0]];
  assign child    = lvl + 1'b1;
  assign lvl_w    = w_eff >> lvl;
  assign lvl_h    = h_eff >> lvl;
  assign child_ok = (32'(child) < LEVEL_COUNT) && ((w_eff >> child) != 0)
                    && ((h_eff >> child) != 0);
  assign pair_done = child_ok && cur_c[0];
  assign produced  = pair_done && cur_r[0];
  assign slot32   = MAX_WIDTH - (MAX_WIDTH >> lvl) + 32'(cur_c >> 1);
  assign slot     = slot32[CW-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pair[k] = PW'(held[lvl[$clog2(LEVEL_COUNT)-1:0]][k]) + PW'(vals[k]);
      quad[k] = QW'(ram_rdata[k*PW +: PW]) + QW'(pair[k]);
    end
  end

  assign ram_wdata = {pair[2], pair[1], pair[0]};
  assign in_fire   = s_tvalid && s_tready;
  assign out_fire  = m_tvalid && m_tready;
  assign ram_we    = out_fire && pair_done && !cur_r[0];

  mpbd_ram #(
    .WIDTH(3 * PW),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot),
    .wdata(ram_wdata),
    .raddr(slot),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    case (state)
      mpbd_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = mpbd_pkg::ST_READ;
        end
      end
      mpbd_pkg::ST_READ: begin
        state_next = mpbd_pkg::ST_EMIT;
      end
      mpbd_pkg::ST_EMIT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = produced ? mpbd_pkg::ST_READ : mpbd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mpbd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpbd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= mpbd_pkg::CFG_W'(1024);
      image_height <= mpbd_pkg::CFG_W'(1024);
      lvl          <= '0;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        col_q[i] <= '0;
        row_q[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == mpbd_pkg::CFG_WIDTH) begin
        image_width <= cfg_data;
      end else begin
        image_height <= cfg_data;
      end
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        col_q[i] <= '0;
        row_q[i] <= '0;
      end
    end else if (in_fire) begin
      lvl <= '0;
    end else if (out_fire) begin
      if (32'(cur_c) + 1 >= lvl_w) begin
        col_q[lvl[$clog2(LEVEL_COUNT)-1:0]] <= '0;
        if (32'(cur_r) + 1 >= lvl_h) begin
          row_q[lvl[$clog2(LEVEL_COUNT)-1:0]] <= '0;
        end else begin
          row_q[lvl[$clog2(LEVEL_COUNT)-1:0]] <= cur_r + 1'b1;
        end
      end else begin
        col_q[lvl[$clog2(LEVEL_COUNT)-1:0]] <= cur_c + 1'b1;
      end
      if (produced) begin
        lvl <= child;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < 3; k++) begin
        vals[k] <= CH'({s_tdata[k*8 +: 8], {mpbd_pkg::FRAC_BITS{1'b0}}});
      end
    end else if (out_fire) begin
      if (child_ok && !cur_c[0]) begin
        for (int k = 0; k < 3; k++) begin
          held[lvl[$clog2(LEVEL_COUNT)-1:0]][k] <= vals[k];
        end
      end
      if (produced) begin
        for (int k = 0; k < 3; k++) begin
          vals[k] <= quad[k][QW-1:2];
        end
      end
    end
  end

  assign m_tdata = {2'b00, vals[2], vals[1], vals[0],
                    mpbd_pkg::POS_W'(cur_r), mpbd_pkg::POS_W'(cur_c),
                    mpbd_pkg::LEVEL_W'(lvl)};
  assign m_tlast = !produced;

`ifndef NO_ASSERTIONS
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output sides active together");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready && !m_tvalid)
    else $error("sequencer did not start a level read");
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(lvl) < LEVEL_COUNT))
    else $error("level beyond the pyramid");
  a_next_level: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> !s_tready && !m_tvalid)
    else $error("missing read cycle before next level");
`endif

endmodule
